### src/sta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_pkg - shared types and constants for the slot table allocator
// Request and response payloads, opcodes, controller states and sizing.
// ----------------------------------------------------------------------------
package sta_pkg;

	localparam int SLOTS       = 64;
	localparam int ENTRY_WIDTH = 32;

	localparam int INDEX_W = 6;
	localparam int VALUE_W = 32;

	// slots reachable through a request index
	localparam int USABLE  = (SLOTS < (1 << INDEX_W)) ? SLOTS : (1 << INDEX_W);
	localparam int IDX_W   = (USABLE > 1) ? $clog2(USABLE) : 1;
	localparam int STORE_W = (ENTRY_WIDTH < VALUE_W) ? ENTRY_WIDTH : VALUE_W;

	localparam logic [INDEX_W:0] SLOT_LIMIT = (INDEX_W + 1)'(USABLE);

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_ADD_AT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_GET    = 2'd3;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [INDEX_W-1:0] slot_index;
		logic [VALUE_W-1:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] result_index;
		logic [VALUE_W-1:0] old_value;
		logic               was_present;
		logic               status;
	} rsp_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} sta_cmd_t;

endpackage

### src/sta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_ctrl - request sequencer
// Takes one request beat, runs the execute cycle and holds the response valid.
// ----------------------------------------------------------------------------
module sta_ctrl import sta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output sta_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_nxt;
	logic       rsp_valid_q;
	logic       accept;

	assign accept = req_valid && !req_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CTL_IDLE: begin
				if (accept) begin
					state_nxt = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				state_nxt = CTL_IDLE;
			end
			default: begin
				state_nxt = CTL_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			CTL_IDLE: begin
				req_stall   = rsp_valid_q && rsp_stall;
				cmd.capture = req_valid && !(rsp_valid_q && rsp_stall);
			end
			CTL_EXEC: begin
				cmd.execute = 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.execute) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef NO_ASSERTIONS
	a_capture_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == CTL_EXEC) && !rsp_valid_q)
		else $error("capture not followed by execute with free response register");

	a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> rsp_valid_q && (state_q == CTL_IDLE))
		else $error("execute did not load a response");
`endif

endmodule

### src/sta_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_datapath - slot store, occupancy bitmap and response register
// Lowest free slot search, one-port slot memory and result formation.
// ----------------------------------------------------------------------------
module sta_datapath import sta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sta_cmd_t cmd,
	input  req_t     req,
	output rsp_t     rsp
);

	function automatic logic [IDX_W-1:0] lowest_free(input logic [USABLE-1:0] occ);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = USABLE - 1; i >= 0; i--) begin
			if (!occ[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

	logic [STORE_W-1:0] mem [USABLE];

	logic [USABLE-1:0]  occ_q;
	logic [STORE_W-1:0] rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               in_range;

	req_t               req_s1;
	logic [IDX_W-1:0]   free_s1;
	logic               full_s1;
	logic               busy_s1;
	logic               in_range_s1;

	rsp_t               rsp_q;
	rsp_t               rsp_nxt;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic               set_bit;
	logic               clr_bit;

	assign rd_addr  = req.slot_index[IDX_W-1:0];
	assign in_range = {1'b0, req.slot_index} < SLOT_LIMIT;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_data_q   <= mem[rd_addr];
			req_s1      <= req;
			free_s1     <= lowest_free(occ_q);
			full_s1     <= &occ_q;
			busy_s1     <= in_range && occ_q[rd_addr];
			in_range_s1 <= in_range;
		end
	end

	always_comb begin
		rsp_nxt.result_index = req_s1.slot_index;
		rsp_nxt.old_value    = '0;
		rsp_nxt.was_present  = 1'b0;
		rsp_nxt.status       = ST_OK;
		wr_en                = 1'b0;
		wr_addr              = req_s1.slot_index[IDX_W-1:0];
		set_bit              = 1'b0;
		clr_bit              = 1'b0;
		if (req_s1.opcode == OP_ADD) begin
			if (full_s1) begin
				rsp_nxt.result_index = '0;
				rsp_nxt.status       = ST_FULL;
			end else begin
				rsp_nxt.result_index = INDEX_W'(free_s1);
				wr_addr              = free_s1;
				wr_en                = 1'b1;
				set_bit              = 1'b1;
			end
		end else if (!in_range_s1) begin
			if (req_s1.opcode == OP_ADD_AT) begin
				rsp_nxt.status = ST_FULL;
			end
		end else begin
			rsp_nxt.was_present = busy_s1;
			if (busy_s1) begin
				rsp_nxt.old_value = VALUE_W'(rd_data_q);
			end
			case (req_s1.opcode)
				OP_ADD_AT: begin
					wr_en   = 1'b1;
					set_bit = 1'b1;
				end
				OP_REMOVE: begin
					clr_bit = 1'b1;
				end
				OP_GET: begin
					wr_en = 1'b0;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && wr_en) begin
			mem[wr_addr] <= req_s1.entry_value[STORE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.execute) begin
			if (set_bit) begin
				occ_q[wr_addr] <= 1'b1;
			end else if (clr_bit) begin
				occ_q[wr_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	a_add_sets_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute && (req_s1.opcode == OP_ADD) && !full_s1
		|=> $countones(occ_q) == $past($countones(occ_q)) + 1)
		else $error("add did not claim exactly one slot");

	a_remove_clears_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute && (req_s1.opcode == OP_REMOVE) && busy_s1
		|=> $countones(occ_q) + 1 == $past($countones(occ_q)))
		else $error("remove did not free exactly one slot");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture && !(&occ_q) |=> !full_s1)
		else $error("full flagged with a free slot");
`endif

endmodule

### src/slot_table_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_allocator - slot table with lowest free slot allocation
// Add, add-at, remove and get on a fixed table guarded by an occupancy bitmap.
// ----------------------------------------------------------------------------
// On the accept edge a request reads the slot memory and latches the lowest
// free slot from the bitmap; the next edge writes the memory and bitmap and
// loads the response register. req_stall is high in the execute state, so
// a new request is taken only once the last one is through; the response
// register lets the next request in at the same edge the previous response
// beat is taken, and req_stall stays high while a response is held with
// rsp_stall high. The bitmap clears at reset; there is no memory clearing pass.
module slot_table_allocator import sta_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	sta_cmd_t cmd;

	sta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	sta_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

### tb/slot_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_checker - response checker for the slot table allocator
// Watches both channels. Each request beat is run through a local copy of
// the slot table and bitmap; each response beat is compared field by field
// with the oldest owed response.
// ----------------------------------------------------------------------------
module slot_table_checker import sta_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   errors,
	output int   owed
);

	logic [STORE_W-1:0] slot_mem [USABLE];
	logic [USABLE-1:0]  occupied;
	rsp_t               owed_rsp_q [$];
	int                 err_count = 0;

	assign errors = err_count;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t checker: %s got %0h want %0h", $time, what, got, want);
		err_count++;
	endtask

	// applies one request to the local table and returns the response it owes
	task automatic table_op(input req_t r, output rsp_t e);
		int                 free_slot;
		logic               in_range;
		logic [STORE_W-1:0] val;
		e = '0;
		e.result_index = r.slot_index;
		e.status = ST_OK;
		val = r.entry_value[STORE_W-1:0];
		in_range = int'(r.slot_index) < USABLE;
		if (r.opcode == OP_ADD) begin
			free_slot = -1;
			for (int i = USABLE - 1; i >= 0; i--) begin
				if (!occupied[i]) free_slot = i;
			end
			if (free_slot < 0) begin
				e.result_index = '0;
				e.status = ST_FULL;
			end else begin
				slot_mem[free_slot] = val;
				occupied[free_slot] = 1'b1;
				e.result_index = INDEX_W'(free_slot);
			end
		end else if (!in_range) begin
			if (r.opcode == OP_ADD_AT) e.status = ST_FULL;
		end else begin
			if (occupied[r.slot_index]) begin
				e.was_present = 1'b1;
				e.old_value = VALUE_W'(slot_mem[r.slot_index]);
			end
			if (r.opcode == OP_ADD_AT) begin
				slot_mem[r.slot_index] = val;
				occupied[r.slot_index] = 1'b1;
			end else if (r.opcode == OP_REMOVE) begin
				occupied[r.slot_index] = 1'b0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t fresh;
		if (!arst_n) begin
			occupied = '0;
			owed_rsp_q.delete();
			owed <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp_q.size() == 0) begin
					flag_mismatch("response beat with nothing owed, result_index",
						64'(rsp.result_index), 64'd0);
				end else begin
					want = owed_rsp_q.pop_front();
					if (rsp.result_index !== want.result_index)
						flag_mismatch("result_index", 64'(rsp.result_index),
							64'(want.result_index));
					if (rsp.old_value !== want.old_value)
						flag_mismatch("old_value", 64'(rsp.old_value),
							64'(want.old_value));
					if (rsp.was_present !== want.was_present)
						flag_mismatch("was_present", 64'(rsp.was_present),
							64'(want.was_present));
					if (rsp.status !== want.status)
						flag_mismatch("status", 64'(rsp.status), 64'(want.status));
				end
			end
			if (req_valid && !req_stall) begin
				table_op(req, fresh);
				owed_rsp_q.push_back(fresh);
			end
			owed <= owed_rsp_q.size();
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - top level for the slot table allocator
// Directed requests on the table edges, then random phases that fill, drain
// and churn the table, with random gaps and stalls on both channels. The
// checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module testbench;
	import sta_pkg::*;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	localparam int QUIET_LIMIT = 4000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int   errors;
	int   owed;
	int   quiet     = 0;
	bit   calm      = 1'b0;

	always #10 clk = ~clk;

	slot_table_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	slot_table_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.owed      (owed)
	);

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 33);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_req(input req_t item);
		while (!calm && $urandom_range(99) < 33) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// holds the request side until every owed response beat has gone
	task automatic drain_wait();
		req_valid <= 1'b0;
		do @(negedge clk); while (owed != 0);
		@(posedge clk);
	endtask

	function automatic req_t random_req(input mix_t mix);
		req_t r;
		int   roll;
		int   add_w;
		int   at_w;
		int   rem_w;
		case (mix)
			MIX_FILL:  begin add_w = 65; at_w = 10; rem_w = 10; end
			MIX_DRAIN: begin add_w = 10; at_w = 5;  rem_w = 65; end
			default:   begin add_w = 30; at_w = 20; rem_w = 25; end
		endcase
		roll = $urandom_range(99);
		if (roll < add_w) r.opcode = OP_ADD;
		else if (roll < add_w + at_w) r.opcode = OP_ADD_AT;
		else if (roll < add_w + at_w + rem_w) r.opcode = OP_REMOVE;
		else r.opcode = OP_GET;
		r.slot_index = INDEX_W'($urandom_range((1 << INDEX_W) - 1));
		roll = $urandom_range(99);
		if (roll < 8) r.entry_value = '0;
		else if (roll < 16) r.entry_value = '1;
		else r.entry_value = VALUE_W'($urandom);
		return r;
	endfunction

	initial begin
		mix_t mix;
		int   len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req('{OP_GET,    6'd0,  32'h0000_0000});
		send_req('{OP_REMOVE, 6'd63, 32'h0000_0000});
		send_req('{OP_ADD,    6'd17, 32'h0000_0000});
		send_req('{OP_ADD,    6'd0,  32'hFFFF_FFFF});
		send_req('{OP_ADD_AT, 6'd63, 32'hA5A5_A5A5});
		send_req('{OP_ADD_AT, 6'd63, 32'h5A5A_5A5A});
		send_req('{OP_GET,    6'd63, 32'hFFFF_FFFF});
		send_req('{OP_GET,    6'd1,  32'h0000_0000});
		send_req('{OP_REMOVE, 6'd0,  32'h0000_0000});
		send_req('{OP_GET,    6'd0,  32'h0000_0000});
		send_req('{OP_ADD,    6'd63, 32'h1234_5678});
		send_req('{OP_REMOVE, 6'd63, 32'h0000_0000});
		send_req('{OP_REMOVE, 6'd63, 32'h0000_0000});
		send_req('{OP_ADD_AT, 6'd2,  32'h8000_0000});
		send_req('{OP_ADD,    6'd0,  32'h0000_0001});
		send_req('{OP_GET,    6'd2,  32'h0000_0000});
		send_req('{OP_ADD_AT, 6'd0,  32'hDEAD_BEEF});
		send_req('{OP_REMOVE, 6'd1,  32'h0000_0000});
		send_req('{OP_ADD,    6'd5,  32'h7FFF_FFFF});
		send_req('{OP_GET,    6'd1,  32'h0000_0000});
		drain_wait();

		// fill past full, drain, then churn, twice; the third phase runs without gaps or response stalls
		for (int p = 0; p < 6; p++) begin
			mix = mix_t'(p % 3);
			len = (mix == MIX_FILL) ? 200 : (mix == MIX_DRAIN) ? 150 : 225;
			calm = (p == 2);
			repeat (len) send_req(random_req(mix));
			calm = 1'b0;
			drain_wait();
		end

		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
